[rtl/fba_pkg.sv]
// ----------------------------------------------------------------------------
// fba_pkg
// shared types, codes and helpers for the frame bitmap allocator
// ----------------------------------------------------------------------------
`default_nettype none

package fba_pkg;

    localparam int unsigned WORD_BITS  = 32;
    localparam int unsigned PAGE_SHIFT = 12;
    localparam logic [31:0] FULL_WORD  = 32'hffff_ffff;

    // request codes
    localparam logic [1:0] OP_FIND   = 2'd0;
    localparam logic [1:0] OP_MARK   = 2'd1;
    localparam logic [1:0] OP_UNMARK = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] frame_address;
    } t_fba_in;

    typedef struct packed {
        logic [26:0] free_frame_address;
        logic        found;
        logic        frame_is_free;
        logic        out_of_range;
    } t_fba_out;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND_RD,
        ST_FIND_CHK,
        ST_ACC_RD,
        ST_ACC_FIN
    } t_fba_state;

    // kind of result word loaded into the output register
    typedef enum logic [1:0] {
        RES_ZERO,
        RES_FOUND,
        RES_QUERY,
        RES_OOR
    } t_fba_res;

    typedef struct packed {
        logic     clr_we;
        logic     capture;
        logic     rd_scan;
        logic     rd_frame;
        logic     scan_inc;
        logic     wr_rmw;
        logic     load;
        t_fba_res res;
    } t_fba_cmd;

    typedef struct packed {
        logic       clr_last;
        logic       scan_end;
        logic       word_full;
        logic       oor;
        logic [1:0] op;
        logic       out_free;
    } t_fba_sts;

    // index of the lowest clear bit, by halving
    function automatic logic [4:0] low_zero_idx(input logic [31:0] w);
        logic [31:0] v;
        logic [15:0] v16;
        logic [7:0]  v8;
        logic [3:0]  v4;
        logic [1:0]  v2;
        logic [4:0]  idx;
        v      = ~w;
        idx[4] = (v[15:0] == 16'd0);
        v16    = idx[4] ? v[31:16] : v[15:0];
        idx[3] = (v16[7:0] == 8'd0);
        v8     = idx[3] ? v16[15:8] : v16[7:0];
        idx[2] = (v8[3:0] == 4'd0);
        v4     = idx[2] ? v8[7:4] : v8[3:0];
        idx[1] = (v4[1:0] == 2'd0);
        v2     = idx[1] ? v4[3:2] : v4[1:0];
        idx[0] = ~v2[0];
        return idx;
    endfunction

endpackage

`default_nettype wire

[rtl/fba_datapath.sv]
// ----------------------------------------------------------------------------
// fba_datapath
// bitmap memory, request registers, scan index and output register
// ----------------------------------------------------------------------------
`default_nettype none

module fba_datapath
    import fba_pkg::*;
#(
    parameter int unsigned MAX_FRAMES = 32768
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic [15:0] i_cfg_data,
    input  wire t_fba_in     i_in_data,
    input  wire t_fba_cmd    i_cmd,
    output t_fba_sts         o_sts,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_fba_out         o_out_data
);

    localparam int unsigned NWORDS = MAX_FRAMES / WORD_BITS;
    localparam int unsigned AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int unsigned CW     = AW + 1;
    localparam int unsigned LW     = (CW > 11) ? CW : 11;
    localparam logic [20:0] FRAME_LIMIT = 21'(MAX_FRAMES);

    logic [15:0]   r_frame_count;
    logic [1:0]    r_op;
    logic [19:0]   r_frame;
    logic          r_oor;
    logic [CW-1:0] r_scan;
    logic [AW-1:0] r_clr;
    logic [31:0]   r_rd_data;
    logic [31:0]   r_mem [NWORDS];
    logic          r_out_valid;
    t_fba_out      r_out_data;
    t_fba_out      n_out_data;

    logic [19:0]   w_in_frame;
    logic [AW-1:0] w_fword;
    logic [31:0]   w_mask;
    logic [31:0]   w_rmw_word;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [31:0]   w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;
    logic [4:0]    w_low_zero;
    logic [31:0]   w_fnum;

    assign w_in_frame = i_in_data.frame_address[31:PAGE_SHIFT];
    assign w_fword    = r_frame[AW+4:5];
    assign w_mask     = 32'd1 << r_frame[4:0];
    assign w_rmw_word = (r_op == OP_MARK) ? (r_rd_data | w_mask) : (r_rd_data & ~w_mask);

    // clearing pass shares the single write port
    assign w_we    = i_cmd.clr_we || i_cmd.wr_rmw;
    assign w_waddr = i_cmd.clr_we ? r_clr : w_fword;
    assign w_wdata = i_cmd.clr_we ? 32'd0 : w_rmw_word;
    assign w_re    = i_cmd.rd_scan || i_cmd.rd_frame;
    assign w_raddr = i_cmd.rd_scan ? r_scan[AW-1:0] : w_fword;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= 16'd0;
            r_clr         <= '0;
            r_scan        <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_frame_count <= i_cfg_data;
            end
            if (i_cmd.clr_we) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.capture) begin
                r_scan <= '0;
            end else if (i_cmd.scan_inc) begin
                r_scan <= r_scan + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_in_data.operation;
            r_frame <= w_in_frame;
            r_oor   <= ({1'b0, w_in_frame} >= FRAME_LIMIT);
        end
    end

    assign w_low_zero = low_zero_idx(r_rd_data);
    assign w_fnum     = (32'(r_scan[AW-1:0]) << 5) | 32'(w_low_zero);

    always_comb begin
        n_out_data = '0;
        case (i_cmd.res)
            RES_ZERO: begin
            end
            RES_FOUND: begin
                n_out_data.free_frame_address = {w_fnum[14:0], 12'd0};
                n_out_data.found              = 1'b1;
            end
            RES_QUERY: begin
                n_out_data.frame_is_free = ~r_rd_data[r_frame[4:0]];
            end
            RES_OOR: begin
                n_out_data.out_of_range = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_sts.clr_last  = (r_clr == AW'(NWORDS - 1));
    assign o_sts.scan_end  = (LW'(r_scan) >= LW'(r_frame_count[15:5]))
                          || (r_scan == CW'(NWORDS));
    assign o_sts.word_full = (r_rd_data == FULL_WORD);
    assign o_sts.oor       = r_oor;
    assign o_sts.op        = r_op;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

[rtl/fba_control.sv]
// ----------------------------------------------------------------------------
// fba_control
// request sequencer: clearing pass, word scan and read-modify-write
// ----------------------------------------------------------------------------
`default_nettype none

module fba_control
    import fba_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_in_op,
    output logic            o_in_ready,
    input  wire t_fba_sts   i_sts,
    output t_fba_cmd        o_cmd
);

    t_fba_state r_state;
    t_fba_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.res  = RES_ZERO;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = (i_in_op == OP_FIND) ? ST_FIND_RD : ST_ACC_RD;
                end
            end
            ST_FIND_RD: begin
                if (i_sts.scan_end) begin
                    // nothing free in range
                    if (i_sts.out_free) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_IDLE;
                    end
                end else begin
                    o_cmd.rd_scan = 1'b1;
                    n_state       = ST_FIND_CHK;
                end
            end
            ST_FIND_CHK: begin
                if (i_sts.word_full) begin
                    o_cmd.scan_inc = 1'b1;
                    n_state        = ST_FIND_RD;
                end else if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.res  = RES_FOUND;
                    n_state    = ST_IDLE;
                end
            end
            ST_ACC_RD: begin
                if (!i_sts.oor) begin
                    o_cmd.rd_frame = 1'b1;
                end
                n_state = ST_ACC_FIN;
            end
            ST_ACC_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                    if (i_sts.oor) begin
                        o_cmd.res = RES_OOR;
                    end else if (i_sts.op == OP_QUERY) begin
                        o_cmd.res = RES_QUERY;
                    end else begin
                        o_cmd.wr_rmw = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/frame_bitmap_allocator.sv]
// ----------------------------------------------------------------------------
// frame_bitmap_allocator
// 4 KiB frame allocator over a bitmap of 32-bit words, one bit per frame
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                 word
// cfg       in         i_cfg_valid / o_cfg_ready  frame_count, 16 bits
// in        in         i_in_valid / o_in_ready    t_fba_in (operation, address)
// out       out        o_out_valid / i_out_ready  t_fba_out (one per request)
//
// mark, unmark and query go from acceptance to result through accept, bitmap
// read, then write-back or bit test on the registered read word
// find reads and then checks one bitmap word at a time until a free frame
// turns up or the scan ends, set by the single read port of the bitmap memory
// (one read, then one check per word)
// after reset a clearing pass writes zero to each of the MAX_FRAMES/32 words,
// one per cycle (1024 words at the default size); o_in_ready stays low
// meanwhile, configuration words are taken at any time
// a finished result waits in the output register while the next request is
// accepted; it is only held back at its last step if that register is full
`default_nettype none

module frame_bitmap_allocator
    import fba_pkg::*;
#(
    parameter int unsigned MAX_FRAMES = 32768
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data,
    // requests
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_fba_in     i_in_data,
    // results
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_fba_out         o_out_data
);

    t_fba_cmd w_cmd;
    t_fba_sts w_sts;

    // frame count register is always writable
    assign o_cfg_ready = 1'b1;

    // sequencer: owns the request handshake and steers the datapath
    fba_control u_control (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_op    (i_in_data.operation),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // bitmap memory, scan index and result register
    fba_datapath #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

[rtl/fba_checker.sv]
// ----------------------------------------------------------------------------
// fba_checker
// port-level checks on the frame bitmap allocator
// ----------------------------------------------------------------------------
`default_nettype none

module fba_checker
    import fba_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire t_fba_out    o_out_data
);

    // result stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed while stalled");

    // a found frame comes only from find
    a_found_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.found |->
            !o_out_data.frame_is_free && !o_out_data.out_of_range)
        else $error("found flag with query or range flag");

    // out of range leaves no address and no status bits
    a_oor_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.out_of_range |->
            !o_out_data.found && !o_out_data.frame_is_free
            && (o_out_data.free_frame_address == 27'd0))
        else $error("out of range result carries data");

    // reset starts the clearing pass, no request taken
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("request accepted during bitmap clear");

endmodule

bind frame_bitmap_allocator fba_checker u_fba_checker (.*);

`default_nettype wire

[bench/frame_bitmap_allocator_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_test
// self-checking bench for the frame bitmap allocator: a bit-level shadow of
// the usage bitmap predicts every reply word, which is checked in order
// against the block while both channels idle and stall at random
// ----------------------------------------------------------------------------

module frame_bitmap_allocator_test
    import fba_pkg::*;
();

    localparam int unsigned MAX_FRAMES     = 32768;
    localparam int unsigned NWORDS         = MAX_FRAMES / WORD_BITS;
    // longest quiet spell: clearing pass after reset or a find over every
    // word, plus the longest stall of either side, taken several times over
    localparam int unsigned WATCHDOG_LIMIT = 20000;
    // settle time after the last reply, before the verdict is printed
    localparam int unsigned SETTLE_CYCLES  = 20;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [15:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    t_fba_in     in_data   = '0;
    logic        out_ready = 1'b0;
    logic        o_cfg_ready;
    logic        o_in_ready;
    logic        o_out_valid;
    t_fba_out    o_out_data;

    // shadow of the block: usage bitmap and frame count register
    logic [31:0]  used_map [NWORDS];
    logic [15:0]  managed_frames;
    t_fba_out     pending_replies [$];
    int unsigned  mismatches = 0;
    bit           quiet;
    int unsigned  stall_left = 0;
    t_fba_out     want;

    frame_bitmap_allocator #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // reply to one request, updating the shadow bitmap as the block would
    function automatic t_fba_out alloc_reply(input t_fba_in req);
        t_fba_out    r;
        int unsigned n;
        int unsigned w;
        int unsigned b;
        logic [19:0] frame;
        logic [31:0] byte_addr;
        r     = '0;
        frame = req.frame_address[31:PAGE_SHIFT];
        if (req.operation == OP_FIND) begin
            // scan stops at the bitmap capacity whatever the count says
            n = managed_frames / WORD_BITS;
            if (n > NWORDS)
                n = NWORDS;
            for (w = 0; w < n && !r.found; w++) begin
                if (used_map[w] != FULL_WORD) begin
                    for (b = 0; b < WORD_BITS && !r.found; b++) begin
                        if (!used_map[w][b]) begin
                            byte_addr            = (w * WORD_BITS + b) << PAGE_SHIFT;
                            r.free_frame_address = byte_addr[26:0];
                            r.found              = 1'b1;
                        end
                    end
                end
            end
        end else if (frame >= MAX_FRAMES) begin
            // beyond capacity: flag it, bitmap untouched
            r.out_of_range = 1'b1;
        end else begin
            w = frame / WORD_BITS;
            b = frame % WORD_BITS;
            case (req.operation)
                OP_MARK:   used_map[w][b] = 1'b1;
                OP_UNMARK: used_map[w][b] = 1'b0;
                default:   r.frame_is_free = !used_map[w][b];
            endcase
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // idle length for either side: mostly none, some short, a few long
    function automatic int unsigned idle_span();
        int unsigned roll;
        if (quiet)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 60);
    endfunction

    // byte address of a frame with junk in the ignored offset bits
    function automatic logic [31:0] frame_addr(input int unsigned frame);
        return (frame << PAGE_SHIFT) | ($urandom & 32'h0000_0fff);
    endfunction

    // send one request word; valid is left high so that the next word can
    // follow without a gap, and the reply is predicted at acceptance
    task automatic issue_request(input logic [1:0] op, input logic [31:0] addr,
                                 output t_fba_out reply);
        int unsigned gap;
        t_fba_in     req;
        gap               = idle_span();
        req.operation     = op;
        req.frame_address = addr;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (!o_in_ready);
        reply = alloc_reply(req);
        pending_replies.push_back(reply);
    endtask

    // wait until every reply is back, leaving the request channel idle
    task automatic drain_replies();
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_frame_count(input logic [15:0] count);
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        managed_frames = count;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // count is zero after reset, so find has no word to search
    task automatic test_reset_defaults();
        t_fba_out r;
        issue_request(OP_FIND, 32'h0000_0000, r);
    endtask

    // mark, unmark, query and find over a two-word bitmap, repeated marks
    // and unmarks included
    task automatic test_basic_ops();
        t_fba_out r;
        drain_replies();
        write_frame_count(16'd64);
        issue_request(OP_QUERY,  32'h0000_0abc, r);
        issue_request(OP_MARK,   32'h0000_0fff, r);
        issue_request(OP_QUERY,  32'h0000_0000, r);
        issue_request(OP_MARK,   32'h0000_0000, r);
        issue_request(OP_FIND,   32'h0000_0000, r);
        issue_request(OP_UNMARK, 32'h0000_1000, r);
        issue_request(OP_UNMARK, 32'h0000_0000, r);
        issue_request(OP_FIND,   32'hffff_ffff, r);
        issue_request(OP_MARK,   32'h0001_f000, r);
        issue_request(OP_QUERY,  32'h0001_ffff, r);
    endtask

    // first frame past capacity, all-ones address, and the last real frame
    task automatic test_range_limits();
        t_fba_out r;
        issue_request(OP_MARK,   32'h0800_0000, r);
        issue_request(OP_QUERY,  32'hffff_ffff, r);
        issue_request(OP_UNMARK, 32'hffff_f000, r);
        issue_request(OP_QUERY,  32'h07ff_ffff, r);
        issue_request(OP_MARK,   32'h07ff_f000, r);
        issue_request(OP_QUERY,  32'h07ff_f000, r);
        issue_request(OP_UNMARK, 32'h07ff_f123, r);
    endtask

    // a count below one word, and a count above capacity
    task automatic test_count_edges();
        t_fba_out r;
        drain_replies();
        write_frame_count(16'd31);
        issue_request(OP_FIND, 32'h0000_0000, r);
        drain_replies();
        write_frame_count(16'hffff);
        issue_request(OP_FIND, 32'h5555_5555, r);
    endtask

    // mostly allocate-and-mark pairs with frees and queries in the frame
    // window, so small counts run out of frames; the rest is random noise
    task automatic test_allocation_mix(input logic [15:0] count, input int unsigned items,
                                       input bit calm);
        t_fba_out    r;
        int unsigned window;
        int unsigned roll;
        int unsigned k;
        drain_replies();
        write_frame_count(count);
        quiet  = calm;
        window = (count < 64) ? 64 : count;
        if (window > MAX_FRAMES)
            window = MAX_FRAMES;
        k = 0;
        while (k < items) begin
            roll = $urandom_range(0, 99);
            if (roll < 40) begin
                issue_request(OP_FIND, $urandom, r);
                if (r.found)
                    issue_request(OP_MARK, 32'(r.free_frame_address) | ($urandom & 32'hfff), r);
                else
                    issue_request(OP_UNMARK, frame_addr($urandom_range(0, window - 1)), r);
                k += 2;
            end else begin
                if (roll < 58)
                    issue_request(OP_UNMARK, frame_addr($urandom_range(0, window - 1)), r);
                else if (roll < 73)
                    issue_request(OP_QUERY, frame_addr($urandom_range(0, window - 1)), r);
                else if (roll < 83)
                    issue_request(OP_MARK, frame_addr($urandom_range(0, window - 1)), r);
                else if (roll < 90)
                    issue_request(2'($urandom_range(1, 3)),
                                  frame_addr($urandom_range(0, MAX_FRAMES - 1)), r);
                else
                    issue_request(2'($urandom_range(0, 3)), $urandom, r);
                k++;
            end
        end
        quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // reply side: random back-pressure and in-order checking
    // ------------------------------------------------------------------------

    always @(posedge clk) begin
        if (stall_left != 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 99) < 25)
                stall_left <= idle_span();
        end
    end

    function automatic void flag_field(input string field, input logic [26:0] exp_v,
                                       input logic [26:0] got_v);
        if (exp_v !== got_v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s: expected %h, got %h", field, exp_v, got_v);
        end
    endfunction

    always @(posedge clk) begin
        if (rst_n && o_out_valid && out_ready) begin
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("reply word %h with no request outstanding", o_out_data);
            end else begin
                want = pending_replies.pop_front();
                flag_field("free_frame_address", want.free_frame_address,
                           o_out_data.free_frame_address);
                flag_field("found", 27'(want.found), 27'(o_out_data.found));
                flag_field("frame_is_free", 27'(want.frame_is_free),
                           27'(o_out_data.frame_is_free));
                flag_field("out_of_range", 27'(want.out_of_range),
                           27'(o_out_data.out_of_range));
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: no word moving on any channel for too long ends the run
    // ------------------------------------------------------------------------

    initial begin : watchdog
        int unsigned still;
        still = 0;
        while (still < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
                (cfg_valid && o_cfg_ready))
                still = 0;
            else
                still++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial begin
        foreach (used_map[i])
            used_map[i] = '0;
        managed_frames = '0;
        quiet          = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_basic_ops();
        test_range_limits();
        test_count_edges();

        // small counts exhaust the bitmap; large ones scan past full words
        test_allocation_mix(16'd32,    180, 1'b0);
        test_allocation_mix(16'd64,    160, 1'b1);
        test_allocation_mix(16'd0,     120, 1'b0);
        test_allocation_mix(16'd33,    150, 1'b0);
        test_allocation_mix(16'd160,   180, 1'b0);
        test_allocation_mix(16'd31,    100, 1'b0);
        test_allocation_mix(16'd1024,  180, 1'b1);
        test_allocation_mix(16'd32768, 180, 1'b0);
        test_allocation_mix(16'hffff,  180, 1'b0);
        test_allocation_mix(16'd96,    300, 1'b0);

        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_replies.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
rtl/fba_pkg.sv
rtl/fba_datapath.sv
rtl/fba_control.sv
rtl/frame_bitmap_allocator.sv
rtl/fba_checker.sv
bench/frame_bitmap_allocator_test.sv
